[rtl/wfc_pkg.sv]
`default_nettype none
package wfc_pkg;
	localparam int MAX_WORDS_DEF    = 1024;
	localparam int MAX_WORD_LEN_DEF = 31;
	localparam int CHAR_W           = 8;
	localparam int COUNT_W          = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef logic [CHAR_W-1:0] char_t;

	function automatic logic is_letter(input char_t c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction
endpackage
`default_nettype wire

[rtl/wfc_cell.sv]
`default_nettype none
module wfc_cell #(
	parameter int POS = 0,
	parameter int FW  = 5
) (
	input  wire logic           clk,
	input  wire logic           shift_en,
	input  wire wfc_pkg::char_t prev_char,
	input  wire wfc_pkg::char_t stored_char,
	input  wire logic [FW-1:0]  fill,
	output wfc_pkg::char_t      held_char,
	output logic                eq
);
	import wfc_pkg::*;

	char_t char_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			char_q <= prev_char;
		end
	end

	assign held_char = char_q;
	assign eq = (FW'(POS) >= fill) || (char_q == stored_char);
endmodule
`default_nettype wire

[rtl/word_frequency_counter.sv]
`default_nettype none
// Counts distinct words in a byte stream. A letter beat shifts into a row of letter
// cells; a non-letter that ends a word starts a walk over the table, one stored entry
// per cycle from a single-port read, until a hit or the end of the used entries, and
// the result is then registered. The input stalls during that walk. One result beat
// per completed word.
module word_frequency_counter #(
	parameter int MAX_WORDS    = wfc_pkg::MAX_WORDS_DEF,
	parameter int MAX_WORD_LEN = wfc_pkg::MAX_WORD_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [9:0]       entry_index,
	output logic             is_new,
	output logic [4:0]       word_length,
	output logic [15:0]      occurrence_count,
	output logic [4:0]       longest_length,
	output logic             table_full,
	output logic             was_truncated
);
	import wfc_pkg::*;

	localparam int IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int UW = $clog2(MAX_WORDS + 1);
	localparam int FW = $clog2(MAX_WORD_LEN + 1);

	typedef logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] row_t;

	state_t state_q, state_d;
	logic [FW-1:0] fill_q;
	logic          inside_q, over_q;
	logic [UW-1:0] used_q, scan_q;
	logic [FW-1:0] longest_q;
	logic          rd_vld_q;
	logic [IW-1:0] rd_idx_q;
	row_t          rd_row_q;
	logic [FW-1:0] rd_len_q;
	logic [COUNT_W-1:0] rd_cnt_q;

	logic [IW-1:0]      res_idx_q;
	logic               res_new_q, res_full_q;
	logic [COUNT_W-1:0] res_cnt_q;

	row_t letters_mem [MAX_WORDS];
	logic [FW-1:0] len_mem [MAX_WORDS];
	logic [COUNT_W-1:0] cnt_mem [MAX_WORDS];

	row_t cells_row;
	logic [MAX_WORD_LEN-1:0] cell_eq;

	logic accept_in, letter, shift_en, issue, hit, miss, out_free, out_take;
	logic [COUNT_W-1:0] hit_cnt;

	assign accept_in = in_valid && !in_stall;
	assign letter    = is_letter(char_code);
	assign shift_en  = accept_in && letter && (fill_q < FW'(MAX_WORD_LEN));
	assign out_take  = out_valid && !out_stall;
	assign out_free  = !out_valid || !out_stall;

	for (genvar k = 0; k < MAX_WORD_LEN; k++) begin : g_cell
		wfc_cell #(.POS(k), .FW(FW)) u_cell (
			.clk        (clk),
			.shift_en   (shift_en),
			.prev_char  ((k == 0) ? char_code : cells_row[(k == 0) ? 0 : k-1]),
			.stored_char(rd_row_q[k]),
			.fill       (fill_q),
			.held_char  (cells_row[k]),
			.eq         (cell_eq[k])
		);
	end

	assign hit     = (state_q == ST_SCAN) && rd_vld_q && (rd_len_q == fill_q) && (&cell_eq);
	assign issue   = (state_q == ST_SCAN) && !hit && (scan_q < used_q);
	assign miss    = (state_q == ST_SCAN) && !rd_vld_q && !issue;
	assign hit_cnt = (rd_cnt_q == COUNT_MAX) ? rd_cnt_q : rd_cnt_q + COUNT_W'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept_in && !letter && inside_q) state_d = ST_SCAN;
			ST_SCAN: if (hit || miss) state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_SCAN: in_stall = 1'b1;
			ST_FIN:  in_stall = 1'b1;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			inside_q  <= 1'b0;
			over_q    <= 1'b0;
			used_q    <= '0;
			scan_q    <= '0;
			longest_q <= '0;
			rd_vld_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= issue;
			if (state_q == ST_FIN && out_free) begin
				out_valid <= 1'b1;
			end else if (out_take) begin
				out_valid <= 1'b0;
			end
			if (state_q == ST_IDLE) begin
				scan_q <= '0;
				if (accept_in && letter) begin
					inside_q <= 1'b1;
					if (fill_q < FW'(MAX_WORD_LEN)) begin
						fill_q <= fill_q + FW'(1);
					end else begin
						over_q <= 1'b1;
					end
				end
			end
			if (issue) begin
				scan_q <= scan_q + UW'(1);
			end
			if (miss && (used_q < UW'(MAX_WORDS))) begin
				used_q <= used_q + UW'(1);
				if (fill_q > longest_q) begin
					longest_q <= fill_q;
				end
			end
			if (state_q == ST_FIN && out_free) begin
				fill_q    <= '0;
				inside_q  <= 1'b0;
				over_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_row_q <= letters_mem[scan_q[IW-1:0]];
			rd_len_q <= len_mem[scan_q[IW-1:0]];
			rd_cnt_q <= cnt_mem[scan_q[IW-1:0]];
			rd_idx_q <= scan_q[IW-1:0];
		end
		if (hit) begin
			cnt_mem[rd_idx_q] <= hit_cnt;
		end else if (miss && (used_q < UW'(MAX_WORDS))) begin
			letters_mem[used_q[IW-1:0]] <= cells_row;
			len_mem[used_q[IW-1:0]]     <= fill_q;
			cnt_mem[used_q[IW-1:0]]     <= COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			res_idx_q  <= rd_idx_q;
			res_new_q  <= 1'b0;
			res_full_q <= 1'b0;
			res_cnt_q  <= hit_cnt;
		end else if (miss) begin
			if (used_q < UW'(MAX_WORDS)) begin
				res_idx_q  <= used_q[IW-1:0];
				res_new_q  <= 1'b1;
				res_full_q <= 1'b0;
				res_cnt_q  <= COUNT_W'(1);
			end else begin
				res_idx_q  <= '0;
				res_new_q  <= 1'b0;
				res_full_q <= 1'b1;
				res_cnt_q  <= '0;
			end
		end
		if (state_q == ST_FIN && out_free) begin
			entry_index      <= 10'(res_idx_q);
			is_new           <= res_new_q;
			word_length      <= 5'(fill_q);
			occurrence_count <= res_cnt_q;
			longest_length   <= 5'(longest_q);
			table_full       <= res_full_q;
			was_truncated    <= over_q;
		end
	end

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= used_q)
		else $error("table walk ran past the filled entries");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the finish step");

	a_used_mono: assert property (@(posedge clk) disable iff (!arst_n)
		used_q >= $past(used_q))
		else $error("entry count went down");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_new && table_full))
		else $error("new and full flagged together");
endmodule
`default_nettype wire
